### hdl/tsvm_pkg.sv
`timescale 1ns / 1ps
package tsvm_pkg;

	// default sizes of the stores
	localparam int STACK_DEPTH_DEF   = 32;
	localparam int RAM_WORDS_DEF     = 256;
	localparam int SYS_MEM_WORDS_DEF = 256;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// major opcodes
	localparam logic [3:0] OP_ALU  = 4'h0;
	localparam logic [3:0] OP_STK  = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h6;
	localparam logic [3:0] OP_LDI  = 4'h7;
	localparam logic [3:0] OP_STI  = 4'h8;
	localparam logic [3:0] OP_MOVI = 4'h9;
	localparam logic [3:0] OP_ADDI = 4'ha;
	localparam logic [3:0] OP_JMP  = 4'hb;
	localparam logic [3:0] OP_JZ   = 4'hc;
	localparam logic [3:0] OP_JNZ  = 4'hd;
	localparam logic [3:0] OP_JPOS = 4'he;
	localparam logic [3:0] OP_JNEG = 4'hf;

	// register-register sub-operations
	localparam logic [3:0] ALU_MOV = 4'h2;
	localparam logic [3:0] ALU_AND = 4'h3;
	localparam logic [3:0] ALU_NOT = 4'h4;
	localparam logic [3:0] ALU_OR  = 4'h5;
	localparam logic [3:0] ALU_XOR = 4'h6;
	localparam logic [3:0] ALU_SHR = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'h8;
	localparam logic [3:0] ALU_ADD = 4'h9;
	localparam logic [3:0] ALU_SUB = 4'ha;
	localparam logic [3:0] ALU_MUL = 4'hb;
	localparam logic [3:0] ALU_DIV = 4'hc;
	localparam logic [3:0] ALU_MOD = 4'hd;
	localparam logic [3:0] ALU_LDR = 4'he;
	localparam logic [3:0] ALU_STR = 4'hf;

	// stack sub-operations
	localparam logic [3:0] STK_PUSH  = 4'h0;
	localparam logic [3:0] STK_POP   = 4'h1;
	localparam logic [3:0] STK_PUSHI = 4'h2;

	// system call group and ids
	localparam logic [3:0] SYS_GROUP = 4'hf;
	localparam logic [7:0] SYS_RD    = 8'h00;
	localparam logic [7:0] SYS_WR    = 8'h01;

	// compare register index
	localparam logic [3:0] CR_IDX = 4'hf;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FAULT = 2'd1;
	localparam logic [1:0] STAT_CALL  = 2'd2;

	// instruction classes found by the front
	typedef enum logic [4:0] {
		CL_START, CL_ALU, CL_DIV, CL_LDR, CL_STR, CL_PUSH, CL_POP, CL_PUSHI,
		CL_CALL, CL_SYS0, CL_SYS1, CL_LDI, CL_STI, CL_MOVI, CL_ADDI, CL_JMP, CL_BAD
	} cls_t;

	// decoded word as queued for the back
	typedef struct packed {
		cls_t       cls;
		logic [3:0] opc;
		logic [3:0] x;
		logic [3:0] y;
		logic [3:0] z;
		logic [3:0] ra;
	} item_t;

	// back sequencer states
	typedef enum logic [2:0] {
		S_ISSUE, S_EXEC, S_DIV, S_RAMWB, S_SYSPUSH, S_POP2
	} bst_t;

endpackage

### hdl/tiny_stack_vm_instruction_exec_top.sv
`timescale 1ns / 1ps
// Executor for a small 8-bit register/stack machine, one instruction word per input.
// Input channel s_*: tdata carries the 16-bit instruction, tuser[0] set means start
// program (program counter cleared, instruction ignored).
// Output channel m_*: one word per input; tuser is the status (ok, fault, call
// request), tdata carries next program counter and the external call id.
// cfg_*: writes the system privilege bit; always ready, write only while idle.
// A two-entry queue parts the decoding front from the executing back.
// The back issues each queued word (register read), executes it and registers the result
// in the output register; register-indirect loads and system calls pass through a further
// state, divide and modulo through the divider (bit-serial, one quotient bit per cycle).
// The back finishes one instruction before it issues the next; the queue takes new words.
// If the receiver stalls, the result holds in the output register; the back starts
// no new word until that slot frees, and the queue then fills and drops s_tready.
// Reset clears registers, program counter, stack count, data ram and system memory
// (through per-entry valid bits), and the privilege bit.
module tiny_stack_vm_instruction_exec_top import tsvm_pkg::*; #(
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
	parameter int RAM_WORDS     = RAM_WORDS_DEF,
	parameter int SYS_MEM_WORDS = SYS_MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // instr_word
	input  logic [0:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // next_pc[15:0], call_id[27:16], zero pad
	output logic [1:0]  m_tuser,   // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	item_t dec_item, q_item;
	logic  q_full, q_empty, q_pop;

	assign s_tready  = !q_full;
	assign cfg_ready = 1'b1;

	// decode front
	tsvm_front u_front (
		.kind (s_tuser[0]),
		.word (s_tdata),
		.item (dec_item)
	);

	// queue between front and back
	tsvm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (s_tvalid && !q_full),
		.din    (dec_item),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.dout   (q_item)
	);

	// execution back
	tsvm_back #(
		.STACK_DEPTH   (STACK_DEPTH),
		.RAM_WORDS     (RAM_WORDS),
		.SYS_MEM_WORDS (SYS_MEM_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

### hdl/tsvm_front.sv
`timescale 1ns / 1ps
module tsvm_front import tsvm_pkg::*; (
	input  logic        kind,
	input  logic [15:0] word,
	output item_t       item
);

	// split the word and classify it
	always_comb begin
		item.opc = word[15:12];
		item.x   = word[11:8];
		item.y   = word[7:4];
		item.z   = word[3:0];
		item.ra  = (word[15:12] == OP_ALU || word[15:12] == OP_STK) ? word[7:4] : word[11:8];
		item.cls = CL_BAD;
		if (kind) begin
			item.cls = CL_START;
		end else begin
			unique case (word[15:12])
				OP_ALU: begin
					unique case (word[11:8])
						ALU_MOV, ALU_AND, ALU_NOT, ALU_OR, ALU_XOR, ALU_SHR, ALU_SHL,
						ALU_ADD, ALU_SUB, ALU_MUL: item.cls = CL_ALU;
						ALU_DIV, ALU_MOD: item.cls = CL_DIV;
						ALU_LDR: item.cls = CL_LDR;
						ALU_STR: item.cls = CL_STR;
						default: item.cls = CL_BAD;
					endcase
				end
				OP_STK: begin
					unique case (word[11:8])
						STK_PUSH:  item.cls = CL_PUSH;
						STK_POP:   item.cls = CL_POP;
						STK_PUSHI: item.cls = CL_PUSHI;
						default:   item.cls = CL_BAD;
					endcase
				end
				OP_CALL: begin
					priority if (word[11:8] != SYS_GROUP) item.cls = CL_CALL;
					else if (word[7:0] == SYS_RD) item.cls = CL_SYS0;
					else if (word[7:0] == SYS_WR) item.cls = CL_SYS1;
					else item.cls = CL_BAD;
				end
				OP_LDI:  item.cls = CL_LDI;
				OP_STI:  item.cls = CL_STI;
				OP_MOVI: item.cls = CL_MOVI;
				OP_ADDI: item.cls = CL_ADDI;
				OP_JMP, OP_JZ, OP_JNZ, OP_JPOS, OP_JNEG: item.cls = CL_JMP;
				default: item.cls = CL_BAD;
			endcase
		end
	end

endmodule

### hdl/tsvm_queue.sv
`timescale 1ns / 1ps
module tsvm_queue import tsvm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output item_t dout
);

	localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [QA_W-1:0]  wp_q, rp_q;
	logic [QC_W-1:0]  cnt_q;

	assign full  = (cnt_q == QC_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rp_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + QA_W'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + QA_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QC_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QC_W'(1);
			end
		end
	end

endmodule

### hdl/tsvm_back.sv
`timescale 1ns / 1ps
module tsvm_back import tsvm_pkg::*; #(
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
	parameter int RAM_WORDS     = RAM_WORDS_DEF,
	parameter int SYS_MEM_WORDS = SYS_MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  item_t       q_item,
	output logic        q_pop,
	input  logic        cfg_valid,
	input  logic        cfg_data,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic [1:0]  m_tuser
);

	localparam int SC_W = $clog2(STACK_DEPTH + 1);
	localparam int SI_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int RA_W = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
	localparam int SA_W = (SYS_MEM_WORDS > 1) ? $clog2(SYS_MEM_WORDS) : 1;

	bst_t             state_q, state_nx;
	item_t            cur_q;
	logic [15:0]      pc_q;
	logic             priv_q;
	logic [SC_W-1:0]  cnt_q;
	logic [7:0]       tmp_q;

	// register file
	logic [7:0]  rf_mem [16];
	logic [15:0] rf_vld_q;
	logic [7:0]  rfa_q, rfb_q, cr_q;
	logic        rfa_v_q, rfb_v_q;

	// data ram, stack, system memory
	logic [7:0]           ram_mem [RAM_WORDS];
	logic [RAM_WORDS-1:0] ram_vld_q;
	logic [7:0]           ram_rd_q;
	logic                 ram_rv_q;
	logic [7:0]           stk_mem [STACK_DEPTH];
	logic [7:0]           stk_rd_q;
	logic [7:0]               sys_mem [SYS_MEM_WORDS];
	logic [SYS_MEM_WORDS-1:0] sys_vld_q;
	logic [7:0]               sys_rd_q;
	logic                     sys_rv_q;

	// divider
	logic [7:0] dq_q, dr_q, dv_q;
	logic [2:0] dc_q;
	logic [8:0] dtrial;
	logic       dge;
	logic [7:0] dnr, dnq;

	// output register
	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [15:0] out_pc_q;
	logic [11:0] out_cid_q;

	// control
	logic        issue;
	logic [7:0]  a_val, b_val, v_val, ram_val, sys_val, alu_res;
	logic [11:0] t_val;
	logic [15:0] pc_inc;
	logic        full, emp, jmp_take;
	logic        rf_we;  logic [3:0] rf_wa; logic [7:0] rf_wd;
	logic        ram_we; logic [7:0] ram_wa; logic [7:0] ram_wd; logic [7:0] ram_ra;
	logic        stk_we; logic [7:0] stk_wd; logic [SC_W-1:0] stk_ra;
	logic        sys_we; logic [7:0] sys_wd;
	logic        cnt_inc, cnt_dec, tmp_ld, div_start, pc_ld;
	logic [15:0] pc_nx;
	logic        fin; logic [1:0] fin_status; logic [15:0] fin_pc;
	logic        go_div, go_ramwb, go_syspush, go_pop2;

	assign issue   = (state_q == S_ISSUE) && !q_empty && (!out_valid_q || m_tready);
	assign q_pop   = issue;
	assign a_val   = rfa_v_q ? rfa_q : 8'h00;
	assign b_val   = rfb_v_q ? rfb_q : 8'h00;
	assign v_val   = {cur_q.y, cur_q.z};
	assign t_val   = {cur_q.x, cur_q.y, cur_q.z};
	assign ram_val = ram_rv_q ? ram_rd_q : 8'h00;
	assign sys_val = sys_rv_q ? sys_rd_q : 8'h00;
	assign pc_inc  = pc_q + 16'd1;
	assign full    = (cnt_q == SC_W'(STACK_DEPTH));
	assign emp     = (cnt_q == '0);
	assign ram_ra  = (state_q == S_EXEC) ? a_val : {q_item.y, q_item.z};
	assign stk_ra  = (state_q == S_EXEC) ? cnt_q - SC_W'(2) : cnt_q - SC_W'(1);

	// one restoring division step
	assign dtrial = {dr_q, dq_q[7]};
	assign dge    = (dtrial >= {1'b0, dv_q});
	assign dnr    = dge ? 8'(dtrial - {1'b0, dv_q}) : dtrial[7:0];
	assign dnq    = {dq_q[6:0], dge};

	// combinational alu
	always_comb begin
		unique case (cur_q.x)
			ALU_MOV: alu_res = a_val;
			ALU_AND: alu_res = b_val & a_val;
			ALU_NOT: alu_res = ~a_val;
			ALU_OR:  alu_res = b_val | a_val;
			ALU_XOR: alu_res = b_val ^ a_val;
			ALU_SHR: alu_res = (a_val >= 8'd8) ? 8'h00 : b_val >> a_val[2:0];
			ALU_SHL: alu_res = (a_val >= 8'd8) ? 8'h00 : b_val << a_val[2:0];
			ALU_ADD: alu_res = b_val + a_val;
			ALU_SUB: alu_res = b_val - a_val;
			ALU_MUL: alu_res = 8'(b_val * a_val);
			default: alu_res = 8'h00;
		endcase
	end

	// branch condition on the compare register
	always_comb begin
		unique case (cur_q.opc)
			OP_JMP:  jmp_take = 1'b1;
			OP_JZ:   jmp_take = (cr_q == 8'h00);
			OP_JNZ:  jmp_take = (cr_q != 8'h00);
			OP_JPOS: jmp_take = (cr_q != 8'h00) && !cr_q[7];
			OP_JNEG: jmp_take = cr_q[7];
			default: jmp_take = 1'b0;
		endcase
	end

	// sequencer outputs: write strobes and result
	always_comb begin
		rf_we = 1'b0; rf_wa = cur_q.z; rf_wd = alu_res;
		ram_we = 1'b0; ram_wa = a_val; ram_wd = b_val;
		stk_we = 1'b0; stk_wd = a_val;
		sys_we = 1'b0; sys_wd = stk_rd_q;
		cnt_inc = 1'b0; cnt_dec = 1'b0; tmp_ld = 1'b0; div_start = 1'b0;
		pc_ld = 1'b0; pc_nx = pc_inc;
		fin = 1'b0; fin_status = STAT_OK; fin_pc = pc_q;
		go_div = 1'b0; go_ramwb = 1'b0; go_syspush = 1'b0; go_pop2 = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				pc_ld = 1'b1;
				fin   = 1'b1;
				unique case (cur_q.cls)
					CL_START: pc_nx = 16'h0000;
					CL_ALU:   rf_we = 1'b1;
					CL_DIV: begin
						if (a_val == 8'h00) begin
							fin_status = STAT_FAULT;
						end else begin
							fin = 1'b0; div_start = 1'b1; go_div = 1'b1;
						end
					end
					CL_LDR: begin
						if ({1'b0, a_val} >= 9'(RAM_WORDS)) begin
							fin_status = STAT_FAULT;
						end else begin
							fin = 1'b0; go_ramwb = 1'b1;
						end
					end
					CL_STR: begin
						if ({1'b0, a_val} >= 9'(RAM_WORDS)) fin_status = STAT_FAULT;
						else ram_we = 1'b1;
					end
					CL_PUSH, CL_PUSHI: begin
						stk_wd = (cur_q.cls == CL_PUSHI) ? v_val : a_val;
						if (full) begin
							fin_status = STAT_FAULT;
						end else begin
							stk_we = 1'b1; cnt_inc = 1'b1;
						end
					end
					CL_POP: begin
						rf_wa = cur_q.y; rf_wd = stk_rd_q;
						if (emp) begin
							fin_status = STAT_FAULT;
						end else begin
							rf_we = 1'b1; cnt_dec = 1'b1;
						end
					end
					CL_CALL: fin_status = STAT_CALL;
					CL_SYS0: begin
						priority if (!priv_q || emp) begin
							fin_status = STAT_FAULT;
						end else if ({1'b0, stk_rd_q} >= 9'(SYS_MEM_WORDS)) begin
							cnt_dec = 1'b1; fin_status = STAT_FAULT;
						end else begin
							cnt_dec = 1'b1; fin = 1'b0; go_syspush = 1'b1;
						end
					end
					CL_SYS1: begin
						priority if (!priv_q || emp) begin
							fin_status = STAT_FAULT;
						end else if (cnt_q == SC_W'(1)) begin
							cnt_dec = 1'b1; fin_status = STAT_FAULT;
						end else begin
							cnt_dec = 1'b1; tmp_ld = 1'b1; fin = 1'b0; go_pop2 = 1'b1;
						end
					end
					CL_LDI: begin
						rf_wa = cur_q.x; rf_wd = ram_val;
						if ({1'b0, v_val} >= 9'(RAM_WORDS)) fin_status = STAT_FAULT;
						else rf_we = 1'b1;
					end
					CL_STI: begin
						ram_wd = v_val;
						if ({1'b0, a_val} >= 9'(RAM_WORDS)) fin_status = STAT_FAULT;
						else ram_we = 1'b1;
					end
					CL_MOVI: begin
						rf_we = 1'b1; rf_wa = cur_q.x; rf_wd = v_val;
					end
					CL_ADDI: begin
						rf_we = 1'b1; rf_wa = cur_q.x; rf_wd = a_val + v_val;
					end
					CL_JMP: begin
						if (jmp_take) pc_nx = {4'h0, t_val};
					end
					default: fin_status = STAT_FAULT;
				endcase
				fin_pc = pc_nx;
			end
			S_DIV: begin
				if (dc_q == 3'd7) begin
					fin   = 1'b1;
					rf_we = 1'b1;
					rf_wd = (cur_q.x == ALU_DIV) ? dnq : dnr;
				end
			end
			S_RAMWB: begin
				fin = 1'b1; rf_we = 1'b1; rf_wd = ram_val;
			end
			S_SYSPUSH: begin
				fin = 1'b1; stk_we = 1'b1; stk_wd = sys_val; cnt_inc = 1'b1;
			end
			S_POP2: begin
				fin = 1'b1; cnt_dec = 1'b1;
				if ({1'b0, tmp_q} >= 9'(SYS_MEM_WORDS)) fin_status = STAT_FAULT;
				else sys_we = 1'b1;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_ISSUE: if (issue) state_nx = S_EXEC;
			S_EXEC: begin
				priority if (go_div) state_nx = S_DIV;
				else if (go_ramwb) state_nx = S_RAMWB;
				else if (go_syspush) state_nx = S_SYSPUSH;
				else if (go_pop2) state_nx = S_POP2;
				else state_nx = S_ISSUE;
			end
			S_DIV: if (dc_q == 3'd7) state_nx = S_ISSUE;
			default: state_nx = S_ISSUE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ISSUE;
			pc_q        <= 16'h0000;
			priv_q      <= 1'b0;
			cnt_q       <= '0;
			rf_vld_q    <= '0;
			cr_q        <= 8'h00;
			ram_vld_q   <= '0;
			sys_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (pc_ld) pc_q <= pc_nx;
			if (cfg_valid) priv_q <= cfg_data;
			if (cnt_inc) cnt_q <= cnt_q + SC_W'(1);
			else if (cnt_dec) cnt_q <= cnt_q - SC_W'(1);
			if (rf_we) begin
				rf_vld_q[rf_wa] <= 1'b1;
				if (rf_wa == CR_IDX) cr_q <= rf_wd;
			end
			if (ram_we) ram_vld_q[ram_wa[RA_W-1:0]] <= 1'b1;
			if (sys_we) sys_vld_q[tmp_q[SA_W-1:0]] <= 1'b1;
			if (fin) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// item, divider and result payload
	always_ff @(posedge clk) begin
		if (issue) cur_q <= q_item;
		if (tmp_ld) tmp_q <= stk_rd_q;
		if (div_start) begin
			dq_q <= b_val;
			dv_q <= a_val;
			dr_q <= 8'h00;
			dc_q <= 3'd0;
		end else if (state_q == S_DIV) begin
			dq_q <= dnq;
			dr_q <= dnr;
			dc_q <= dc_q + 3'd1;
		end
		if (fin) begin
			out_status_q <= fin_status;
			out_pc_q     <= fin_pc;
			out_cid_q    <= (fin_status == STAT_CALL) ? t_val : 12'h000;
		end
	end

	// register file, two read ports
	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_wa] <= rf_wd;
		rfa_q   <= rf_mem[q_item.ra];
		rfb_q   <= rf_mem[q_item.z];
		rfa_v_q <= rf_vld_q[q_item.ra];
		rfb_v_q <= rf_vld_q[q_item.z];
	end

	// data ram
	always_ff @(posedge clk) begin
		if (ram_we) ram_mem[ram_wa[RA_W-1:0]] <= ram_wd;
		ram_rd_q <= ram_mem[ram_ra[RA_W-1:0]];
		ram_rv_q <= ram_vld_q[ram_ra[RA_W-1:0]];
	end

	// value stack
	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[cnt_q[SI_W-1:0]] <= stk_wd;
		stk_rd_q <= stk_mem[stk_ra[SI_W-1:0]];
	end

	// system memory
	always_ff @(posedge clk) begin
		if (sys_we) sys_mem[tmp_q[SA_W-1:0]] <= sys_wd;
		sys_rd_q <= sys_mem[stk_rd_q[SA_W-1:0]];
		sys_rv_q <= sys_vld_q[stk_rd_q[SA_W-1:0]];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, out_cid_q, out_pc_q};
	assign m_tuser  = out_status_q;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SC_W'(STACK_DEPTH))
		else $error("stack count above depth");
	a_exec_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> $past(state_q) == S_ISSUE)
		else $error("execute without issue");
	a_exec_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> !out_valid_q)
		else $error("output slot busy during execute");
	a_fin_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> m_tvalid)
		else $error("finished word not presented");
`endif

endmodule
